### rtl/bpeg_pkg.sv
package bpeg_pkg;

	localparam int unsigned LEVEL_W = 21;
	localparam int unsigned DUR_W   = 29;
	localparam int unsigned TIME_W  = 30;
	localparam int unsigned STEP_W  = 24;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned PIDX_W  = 6;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned RATIO_W = FRAC_W + 1;
	localparam int unsigned DATA_W  = STEP_W;

	localparam logic [RATIO_W-1:0] ONE_Q24     = RATIO_W'(1) << FRAC_W;
	localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(4);
	localparam logic [STEP_W-1:0]  RESET_STEP  = STEP_W'(350);

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_POINT_COUNT = 1'b0,
		CFG_TIME_STEP   = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_CUR,
		ST_RD_NEXT,
		ST_LOAD_B,
		ST_DIV,
		ST_MUL,
		ST_MIX,
		ST_OUT
	} state_t;

	function automatic logic [LEVEL_W-1:0] init_level(input int unsigned k);
		logic [LEVEL_W-1:0] v;
		unique case (k)
			1: v = LEVEL_W'(65536);
			2: v = LEVEL_W'(13107);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [DUR_W-1:0] init_duration(input int unsigned k);
		logic [DUR_W-1:0] v;
		unique case (k)
			0: v = DUR_W'(167772);
			1: v = DUR_W'(671089);
			2: v = DUR_W'(3355443);
			3: v = DUR_W'(8388608);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/bpeg_if.sv
interface bpeg_item_if;
	import bpeg_pkg::*;
	logic                valid;
	logic                ready;
	cmd_t                command;
	logic                restart;
	logic [PIDX_W-1:0]   point_index;
	logic [LEVEL_W-1:0]  point_level;
	logic [DUR_W-1:0]    point_duration;

	modport source (output valid, command, restart, point_index, point_level, point_duration,
		input ready);
	modport sink (input valid, command, restart, point_index, point_level, point_duration,
		output ready);
endinterface

interface bpeg_result_if;
	import bpeg_pkg::*;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

interface bpeg_cfg_if;
	import bpeg_pkg::*;
	logic              valid;
	logic              ready;
	cfg_reg_t          index;
	logic [DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/breakpoint_envelope_generator_core.sv
// Piecewise-linear envelope generator over a table of MAX_POINTS breakpoints (level Q5.16,
// duration Q5.24 s). A write item stores one breakpoint. A tick item steps through the table
// reads of the current and next breakpoint, the restoring divider (24 quotient bits of the
// time/duration ratio, one per cycle, and the done step), one multiply, one blend and the
// output load; no new item is taken until its sample is loaded. A tick on the last breakpoint
// skips the divider, multiply and blend; a zero duration or an overrun segment skips the
// divider. A sample that the receiver has not taken holds the next tick in its output stage.
// After reset the block runs a clearing pass over all MAX_POINTS entries that loads the
// default breakpoints, and takes no item meanwhile; configuration writes are always taken and
// must only be made while no tick is in flight.
module breakpoint_envelope_generator_core #(
	parameter int unsigned MAX_POINTS = 64
) (
	input logic           clk,
	input logic           arst_n,
	bpeg_item_if.sink     item,
	bpeg_result_if.source result,
	bpeg_cfg_if.sink      cfg
);
	import bpeg_pkg::*;

	localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(MAX_POINTS - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0]    clr_q;
	logic [COUNT_W-1:0]  point_count_q;
	logic [STEP_W-1:0]   time_step_q;
	logic [IDX_W-1:0]    seg_idx_q;
	logic [TIME_W-1:0]   seg_time_q;
	logic                hold_q;
	logic [LEVEL_W-1:0]  a_q;
	logic [LEVEL_W-1:0]  b_q;
	logic [DUR_W-1:0]    dur_q;
	logic [RATIO_W-1:0]  r_q;
	logic signed [47:0]  prod_q;
	logic [LEVEL_W-1:0]  samp_q;
	logic                res_valid_q;
	logic [LEVEL_W-1:0]  res_sample_q;

	logic [IDX_W-1:0]    last_w;
	logic                item_xfer;
	logic                tick_xfer;
	logic                wr_ok;
	logic                tbl_we;
	logic [IDX_W-1:0]    tbl_waddr;
	logic [LEVEL_W-1:0]  tbl_wlevel;
	logic [DUR_W-1:0]    tbl_wdur;
	logic [IDX_W-1:0]    tbl_raddr;
	logic [LEVEL_W-1:0]  tbl_rlevel;
	logic [DUR_W-1:0]    tbl_rdur;
	logic                special;
	logic                div_start;
	logic                div_done;
	logic [FRAC_W-1:0]   div_quo;
	logic                slot_free;
	logic                load_res;
	logic signed [21:0]  diff_ab;
	logic signed [25:0]  r_s;
	logic signed [47:0]  mix_sum;
	logic [TIME_W-1:0]   t_sum;

	bpeg_table #(
		.DEPTH (MAX_POINTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk    (clk),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wlevel (tbl_wlevel),
		.wdur   (tbl_wdur),
		.raddr  (tbl_raddr),
		.rlevel (tbl_rlevel),
		.rdur   (tbl_rdur)
	);

	bpeg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (seg_time_q),
		.den    (dur_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		if (point_count_q == '0) begin
			last_w = '0;
		end else if (32'(point_count_q) > MAX_POINTS) begin
			last_w = LAST_MAX;
		end else begin
			last_w = IDX_W'(point_count_q - COUNT_W'(1));
		end
	end

	assign special   = (dur_q == '0) || (seg_time_q >= TIME_W'(dur_q));
	assign slot_free = !res_valid_q || result.ready;
	assign item_xfer = item.valid && item.ready;
	assign tick_xfer = item_xfer && (item.command == CMD_TICK);
	assign wr_ok     = 32'(item.point_index) < MAX_POINTS;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == LAST_MAX) state_d = ST_IDLE;
			ST_IDLE:    if (tick_xfer) state_d = ST_RD_CUR;
			ST_RD_CUR:  state_d = ST_RD_NEXT;
			ST_RD_NEXT: state_d = hold_q ? ST_OUT : ST_LOAD_B;
			ST_LOAD_B:  state_d = special ? ST_MUL : ST_DIV;
			ST_DIV:     if (div_done) state_d = ST_MUL;
			ST_MUL:     state_d = ST_MIX;
			ST_MIX:     state_d = ST_OUT;
			ST_OUT:     if (slot_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready = 1'b0;
		tbl_we     = 1'b0;
		tbl_waddr  = IDX_W'(item.point_index);
		tbl_wlevel = item.point_level;
		tbl_wdur   = item.point_duration;
		tbl_raddr  = seg_idx_q;
		div_start  = 1'b0;
		load_res   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				tbl_we     = 1'b1;
				tbl_waddr  = clr_q;
				tbl_wlevel = init_level(32'(clr_q));
				tbl_wdur   = init_duration(32'(clr_q));
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				tbl_we     = item.valid && (item.command == CMD_WRITE) && wr_ok;
			end
			ST_RD_CUR:  tbl_raddr = (seg_idx_q >= last_w) ? last_w : seg_idx_q;
			ST_RD_NEXT: tbl_raddr = seg_idx_q + IDX_W'(1);
			ST_LOAD_B:  div_start = !special;
			ST_OUT:     load_res = slot_free;
			default: ;
		endcase
	end

	always_comb begin
		diff_ab = $signed({1'b0, b_q}) - $signed({1'b0, a_q});
		r_s     = $signed({1'b0, r_q});
		mix_sum = $signed({3'b000, a_q, {FRAC_W{1'b0}}}) + prod_q
			+ $signed(48'd1 << (FRAC_W - 1));
		t_sum   = seg_time_q + TIME_W'(time_step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			point_count_q <= RESET_COUNT;
			time_step_q   <= RESET_STEP;
			seg_idx_q     <= '0;
			seg_time_q    <= '0;
			hold_q        <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_POINT_COUNT: point_count_q <= cfg.data[COUNT_W-1:0];
					CFG_TIME_STEP:   time_step_q <= cfg.data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (tick_xfer && item.restart) begin
				seg_idx_q  <= '0;
				seg_time_q <= '0;
			end
			if (state_q == ST_RD_CUR) begin
				hold_q <= seg_idx_q >= last_w;
			end
			// time advance and segment step
			if (state_q == ST_MIX) begin
				if (t_sum > TIME_W'(dur_q)) begin
					seg_time_q <= '0;
					seg_idx_q  <= seg_idx_q + IDX_W'(1);
				end else begin
					seg_time_q <= t_sum;
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RD_NEXT: begin
				a_q   <= tbl_rlevel;
				dur_q <= tbl_rdur;
			end
			ST_LOAD_B: begin
				b_q <= tbl_rlevel;
				r_q <= (dur_q == '0) ? '0 : ONE_Q24;
			end
			ST_DIV:  if (div_done) r_q <= {1'b0, div_quo};
			ST_MUL:  prod_q <= diff_ab * r_s;
			ST_MIX:  samp_q <= mix_sum[FRAC_W+LEVEL_W-1:FRAC_W];
			default: ;
		endcase
		if (load_res) begin
			res_sample_q <= hold_q ? a_q : samp_q;
		end
	end

	assign cfg.ready     = 1'b1;
	assign result.valid  = res_valid_q;
	assign result.sample = res_sample_q;

`ifndef ASSERT_OFF
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item.ready)
		else $error("item taken during clearing pass");
	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> r_q <= ONE_Q24)
		else $error("blend ratio above one");
	a_blend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !hold_q) |-> (samp_q <= a_q || samp_q <= b_q))
		else $error("sample outside segment levels");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> result.valid)
		else $error("result not presented after load");
`endif

endmodule

### rtl/bpeg_table.sv
module bpeg_table #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [IDX_W-1:0]             waddr,
	input  logic [bpeg_pkg::LEVEL_W-1:0] wlevel,
	input  logic [bpeg_pkg::DUR_W-1:0]   wdur,
	input  logic [IDX_W-1:0]             raddr,
	output logic [bpeg_pkg::LEVEL_W-1:0] rlevel,
	output logic [bpeg_pkg::DUR_W-1:0]   rdur
);
	import bpeg_pkg::*;

	logic [LEVEL_W+DUR_W-1:0] mem [DEPTH];
	logic [LEVEL_W+DUR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wlevel, wdur};
		end
		rdata_q <= mem[raddr];
	end

	assign rlevel = rdata_q[LEVEL_W+DUR_W-1:DUR_W];
	assign rdur   = rdata_q[DUR_W-1:0];

endmodule

### rtl/bpeg_div.sv
module bpeg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bpeg_pkg::TIME_W-1:0] num,
	input  logic [bpeg_pkg::DUR_W-1:0]  den,
	output logic                        done,
	output logic [bpeg_pkg::FRAC_W-1:0] quo
);
	import bpeg_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAC_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [DUR_W-1:0]  den_q;
	logic [FRAC_W-1:0] quo_q;

	logic [TIME_W:0]   sh;
	logic [TIME_W:0]   diff;
	logic              ge;

	always_comb begin
		sh   = {rem_q, 1'b0};
		ge   = sh >= (TIME_W+1)'(den_q);
		diff = sh - (TIME_W+1)'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < TIME_W'(den_q))
		else $error("partial remainder not below divisor");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("done without a finished run");
`endif

endmodule
